// ===== src/assert_macros.svh =====
// Assertion macros used by the substring_first_match RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SFM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SFM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sfm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_pkg
// Types and constants shared by the substring search block.
// ----------------------------------------------------------------------------
package sfm_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int POS_W       = 17;
    localparam int OUT_POS_W   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [POS_W-1:0] TEXT_MAX    = 17'h10000;
    localparam logic [LEN_W-1:0] LEN_MAX     = 5'd16;
    localparam logic [LEN_W-1:0] LEN_MIN     = 5'd1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_PATTERN_LEN  = 3'd2,
        CFG_SEARCH_FROM  = 3'd3,
        CFG_SEARCH_TO    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              last_byte;
    } in_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_POS_W-1:0] match_position;
    } out_t;

    // Search setup handed from the register file to the cell row
    typedef struct packed {
        logic [PATTERN_MAX-1:0][BYTE_W-1:0] aligned;  // pattern byte seen by each cell
        logic [PATTERN_MAX-1:0]             active;   // cell lies inside the pattern
        logic [LEN_W-1:0]                   len;      // clamped pattern length
        logic [OUT_POS_W-1:0]               from;
        logic [POS_W-1:0]                   to;       // clipped window end
    } search_cfg_t;

endpackage

// ===== src/sfm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_cell
// One byte of the text history: holds a byte, passes it on, compares.
// ----------------------------------------------------------------------------
module sfm_cell (
    input  logic                        aclk,
    input  logic                        shift_en,
    input  logic [sfm_pkg::BYTE_W-1:0]  byte_in,
    input  logic [sfm_pkg::BYTE_W-1:0]  pat_byte,
    input  logic                        active,
    output logic [sfm_pkg::BYTE_W-1:0]  byte_out,
    output logic                        hit
);

    logic [sfm_pkg::BYTE_W-1:0] byte_reg;
    logic [sfm_pkg::BYTE_W-1:0] byte_next;

    // compare the byte this cell takes on the transfer
    assign hit = !active || (byte_in == pat_byte);

    assign byte_next = shift_en ? byte_in : byte_reg;

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;

endmodule

// ===== src/sfm_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_cfg
// Configuration registers and per-cell pattern alignment.
// ----------------------------------------------------------------------------
module sfm_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [sfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sfm_pkg::search_cfg_t            search_cfg
);

    logic [sfm_pkg::CFG_DATA_W-1:0] pat_low_reg,  pat_low_next;
    logic [sfm_pkg::CFG_DATA_W-1:0] pat_high_reg, pat_high_next;
    logic [sfm_pkg::LEN_W-1:0]      len_reg,      len_next;
    logic [sfm_pkg::OUT_POS_W-1:0]  from_reg,     from_next;
    logic [sfm_pkg::POS_W-1:0]      to_reg,       to_next;

    logic [sfm_pkg::PATTERN_MAX-1:0][sfm_pkg::BYTE_W-1:0] pat_all;
    logic [sfm_pkg::LEN_W-1:0] len_eff;
    logic [sfm_pkg::LEN_W-1:0] pat_idx;

    // register writes
    always_comb begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        len_next      = len_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        if (cfg_valid) begin
            unique case (sfm_pkg::cfg_idx_t'(cfg_index))
                sfm_pkg::CFG_PATTERN_LOW:  pat_low_next  = cfg_data;
                sfm_pkg::CFG_PATTERN_HIGH: pat_high_next = cfg_data;
                sfm_pkg::CFG_PATTERN_LEN:  len_next  = cfg_data[sfm_pkg::LEN_W-1:0];
                sfm_pkg::CFG_SEARCH_FROM:  from_next = cfg_data[sfm_pkg::OUT_POS_W-1:0];
                sfm_pkg::CFG_SEARCH_TO:    to_next   = cfg_data[sfm_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            len_reg      <= sfm_pkg::LEN_MIN;
            from_reg     <= '0;
            to_reg       <= sfm_pkg::TEXT_MAX;
        end else begin
            pat_low_reg  <= pat_low_next;
            pat_high_reg <= pat_high_next;
            len_reg      <= len_next;
            from_reg     <= from_next;
            to_reg       <= to_next;
        end
    end

    // clamp length to 1..16, clip window end to the text limit
    always_comb begin
        if (len_reg == '0) begin
            len_eff = sfm_pkg::LEN_MIN;
        end else if (len_reg > sfm_pkg::LEN_MAX) begin
            len_eff = sfm_pkg::LEN_MAX;
        end else begin
            len_eff = len_reg;
        end
    end

    assign pat_all = {pat_high_reg, pat_low_reg};

    // cell i sees the byte i places back from the newest one and gets pattern byte len-1-i
    always_comb begin
        pat_idx = '0;
        for (int i = 0; i < sfm_pkg::PATTERN_MAX; i++) begin
            pat_idx                  = len_eff - sfm_pkg::LEN_W'(i) - sfm_pkg::LEN_MIN;
            search_cfg.aligned[i]    = pat_all[pat_idx[sfm_pkg::LEN_W-2:0]];
            search_cfg.active[i]     = (sfm_pkg::LEN_W'(i) < len_eff);
        end
        search_cfg.len  = len_eff;
        search_cfg.from = from_reg;
        search_cfg.to   = (to_reg > sfm_pkg::TEXT_MAX) ? sfm_pkg::TEXT_MAX : to_reg;
    end

endmodule

// ===== src/substring_first_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_first_match
// Streaming first-occurrence search of a 1 to 16 byte pattern in a text.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock and gives one result per text: the
// start of the first match inside [search_from, search_to) as soon as its last
// byte arrives, or found = 0 with the last byte. The result is registered and
// appears the cycle after the byte that settles it; a new byte is taken in
// the same cycle as long as the result register is empty or being drained.
// A row of 16 byte cells shifts the text history and compares it against the
// pattern. Bytes that follow a match are swallowed until the last byte of the
// text. Configuration writes are taken every cycle and apply from the next
// byte on.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module substring_first_match (
    input  logic                            aclk,
    input  logic                            aresetn,
    // text input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sfm_pkg::in_t                    s_data,
    // result output
    output logic                            m_valid,
    input  logic                            m_ready,
    output sfm_pkg::out_t                   m_data,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int NP = sfm_pkg::PATTERN_MAX;
    localparam int WW = sfm_pkg::POS_W + 1;

    sfm_pkg::search_cfg_t search_cfg;

    logic [NP-1:0][sfm_pkg::BYTE_W-1:0] cell_in;
    logic [NP-1:0][sfm_pkg::BYTE_W-1:0] cell_out;
    logic [NP-1:0]                      cell_hit;

    logic [sfm_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      given_reg, given_next;
    logic                      m_valid_reg, m_valid_next;
    sfm_pkg::out_t             m_data_reg, m_data_next;

    logic          s_xfer;
    logic          shift_en;
    logic [WW-1:0] pos1;
    logic [WW-1:0] start;
    logic          window_ok;
    logic          hit;

    assign cfg_ready = 1'b1;

    sfm_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .search_cfg (search_cfg)
    );

    // history row: cell 0 takes the new byte, each cell feeds the next
    assign shift_en = s_xfer && !given_reg;

    for (genvar i = 0; i < NP; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign cell_in[i] = s_data.text_byte;
        end else begin : g_body
            assign cell_in[i] = cell_out[i-1];
        end
        sfm_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .byte_in  (cell_in[i]),
            .pat_byte (search_cfg.aligned[i]),
            .active   (search_cfg.active[i]),
            .byte_out (cell_out[i]),
            .hit      (cell_hit[i])
        );
    end

    // window check for a match ending on the byte now arriving
    assign pos1      = {1'b0, pos_reg} + WW'(1);
    assign start     = pos1 - WW'(search_cfg.len);
    assign window_ok = (pos1 >= WW'(search_cfg.len)) && (pos1 <= WW'(search_cfg.to))
                       && (start >= WW'(search_cfg.from));
    assign hit       = window_ok && (&cell_hit);

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    // text tracking and result generation
    always_comb begin
        pos_next     = pos_reg;
        given_next   = given_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (s_xfer) begin
            priority if (given_reg) begin
                if (s_data.last_byte) begin
                    pos_next   = '0;
                    given_next = 1'b0;
                end
            end else if (hit) begin
                m_valid_next               = 1'b1;
                m_data_next.found          = 1'b1;
                m_data_next.match_position = start[sfm_pkg::OUT_POS_W-1:0];
                if (s_data.last_byte) begin
                    pos_next = '0;
                end else begin
                    given_next = 1'b1;
                end
            end else if (s_data.last_byte) begin
                m_valid_next               = 1'b1;
                m_data_next.found          = 1'b0;
                m_data_next.match_position = '0;
                pos_next                   = '0;
            end else if (pos_reg < sfm_pkg::TEXT_MAX) begin
                pos_next = pos_reg + sfm_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            given_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            given_reg   <= given_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `SFM_ASSERT(a_notfound_pos_zero, aclk, aresetn,
        (m_valid_reg && !m_data_reg.found) |-> (m_data_reg.match_position == '0),
        "not-found result carries a nonzero position")
    `SFM_ASSERT(a_last_rearms, aclk, aresetn,
        (s_xfer && s_data.last_byte) |=> ((pos_reg == '0) && !given_reg),
        "last byte did not rearm the search")
    `SFM_ASSERT(a_found_in_window, aclk, aresetn,
        (m_valid_reg && m_data_reg.found) |-> (m_data_reg.match_position >= search_cfg.from),
        "match reported before the window start")
    `SFM_ASSERT_ALWAYS(a_reset_clears_out, aclk,
        !aresetn |=> !m_valid_reg,
        "result valid right after reset")

endmodule
